[rtl/bmm_pkg.sv]
package bmm_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DIVD_W    = 2 * WORD_W + 1;
    localparam logic [WORD_W-1:0] MOD_RESET = 32'd65521;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DINIT_W,
        ST_DRD,
        ST_DMUL,
        ST_DRED,
        ST_DRED_W,
        ST_INV_W,
        ST_EUC,
        ST_EDIV_W,
        ST_EMUL,
        ST_ERED,
        ST_ERED_W,
        ST_FMUL,
        ST_FRED,
        ST_FRED_W,
        ST_URD,
        ST_UMUL,
        ST_URED,
        ST_URED_W,
        ST_USUB,
        ST_USUB_W,
        ST_UNXT,
        ST_FIN,
        ST_ORD,
        ST_OLD
    } state_t;

endpackage

[rtl/bmm_divider.sv]
module bmm_divider (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bmm_pkg::DIVD_W-1:0]       dividend,
    input  logic [bmm_pkg::WORD_W-1:0]       divisor,
    output logic                             done,
    output logic [bmm_pkg::WORD_W-1:0]       quotient,
    output logic [bmm_pkg::WORD_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(bmm_pkg::DIVD_W + 1);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [bmm_pkg::DIVD_W-1:0]    num_reg;
    logic [bmm_pkg::WORD_W-1:0]    rem_reg;
    logic [bmm_pkg::WORD_W-1:0]    dvs_reg;
    logic [bmm_pkg::WORD_W:0]      trial;
    logic                          ge;

    // one restoring step per cycle, quotient bits shift in behind the dividend
    always_comb begin
        trial = {rem_reg, num_reg[bmm_pkg::DIVD_W-1]};
        ge    = trial >= {1'b0, dvs_reg};
    end

    assign done      = busy_reg && (cnt_reg == '0);
    assign quotient  = num_reg[bmm_pkg::WORD_W-1:0];
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(bmm_pkg::DIVD_W);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg && (cnt_reg != '0)) begin
            num_reg <= {num_reg[bmm_pkg::DIVD_W-2:0], ge};
            if (ge) begin
                rem_reg <= bmm_pkg::WORD_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[bmm_pkg::WORD_W-1:0];
            end
        end
    end

endmodule

[rtl/berlekamp_massey_mod_p_unit.sv]
// Berlekamp-Massey synthesis over GF(p), one symbol per input transaction.
// Input channel s_*: s_symbol and s_end_of_sequence, valid/ready handshake.
// Result channel m_*: on the symbol marked last the block emits the linear
// complexity L (m_is_length high), then C[L] down to C[0]; m_last_result
// marks the C[0] transaction. m_overflow reports symbols dropped beyond
// MAX_SEQ. cfg_we/cfg_wdata write the modulus; the user must write it
// only while the block is idle, the block itself does not enforce this.
// All modular reductions run on one 65-step remainder/divide unit, fed by
// 32x32 products in prod_reg. Each symbol is first reduced, then min(L,n)
// products are accumulated for the discrepancy; when it is nonzero, the
// previous discrepancy is inverted with up to ~46 Euclid steps, the scale
// factor is formed and all 33 coefficient entries are updated.
// One symbol is in work at a time; s_ready is high only between symbols.
// The result run leaves through an output register, one read state and one
// load state per result; a stalled receiver holds the sequencer.
// After the last result is loaded the block is ready for a new sequence.
// Reset (synchronous, active low) sets modulus 65521 and empties both
// polynomials; no clearing pass is needed.
module berlekamp_massey_mod_p_unit #(
    parameter int MAX_SEQ = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_symbol,
    input  logic        s_end_of_sequence,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_value,
    output logic        m_is_length,
    output logic        m_overflow,
    output logic        m_last_result
);

    localparam int W  = bmm_pkg::WORD_W;
    localparam int DW = bmm_pkg::DIVD_W;
    localparam int IW = $clog2(MAX_SEQ + 1);
    localparam int HW = $clog2(MAX_SEQ);
    localparam int KW = $clog2(MAX_SEQ + 2);

    bmm_pkg::state_t state_reg, state_next;

    logic [W-1:0]    modulus_reg;
    logic [IW-1:0]   cnt_reg, cnt_next;
    logic [IW-1:0]   len_reg, len_next;
    logic [IW:0]     lui_reg, lui_next;
    logic [W-1:0]    ld_reg, ld_next;
    logic            ovf_reg, ovf_next;
    logic            eos_reg, eos_next;
    logic [W-1:0]    d_reg, d_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            lenchg_reg, lenchg_next;
    logic [W-1:0]    f_reg, f_next;
    logic [W-1:0]    r0_reg, r0_next;
    logic [W-1:0]    r1_reg, r1_next;
    logic [W-1:0]    t0_reg, t0_next;
    logic [W-1:0]    t1_reg, t1_next;
    logic [2*W-1:0]  prod_reg, prod_next;
    logic [W-1:0]    cj_reg, cj_next;
    logic [W:0]      sub_reg, sub_next;
    logic [KW-1:0]   k_reg, k_next;

    logic [W-1:0]    out_val_reg, out_val_next;
    logic            out_len_reg, out_len_next;
    logic            out_ovf_reg, out_ovf_next;
    logic            out_last_reg, out_last_next;
    logic            m_valid_reg, m_valid_next;

    // coefficient stores and symbol history
    logic [W-1:0]    c_mem [0:MAX_SEQ];
    logic [W-1:0]    b_mem [0:MAX_SEQ];
    logic [W-1:0]    h_mem [0:MAX_SEQ-1];
    logic [MAX_SEQ:0] c_vld_reg, b_vld_reg;

    logic [IW-1:0]   c_ra, c_rb, c_waddr, b_raddr;
    logic [HW-1:0]   h_raddr;
    logic            c_we, b_we, h_we, clr;
    logic [W-1:0]    c_wdata, b_wdata;
    logic [W-1:0]    c_rda_reg, c_rdb_reg, b_rd_reg, h_rd_reg;
    logic            c_va_reg, c_vb_reg, b_v_reg;
    logic            c_za_reg, c_zb_reg, b_z_reg;
    logic [W-1:0]    c_a_val, c_b_val, b_val;

    logic            div_start, div_done;
    logic [DW-1:0]   div_dividend;
    logic [W-1:0]    div_divisor, div_quot, div_rem, red_rem;

    logic            s_acc, m_acc, m_small, slot_free, j_in;
    logic [IW:0]     shift, j_full;
    logic [W:0]      nt_sum;

    assign s_acc     = s_valid && s_ready;
    assign m_acc     = m_valid_reg && m_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_small   = modulus_reg < W'(2);
    assign red_rem   = m_small ? '0 : div_rem;
    assign shift     = {1'b0, cnt_reg} - lui_reg;
    assign j_full    = {1'b0, idx_reg} + shift;
    assign j_in      = j_full <= (IW+1)'(MAX_SEQ);

    assign c_a_val = c_va_reg ? c_rda_reg : W'(c_za_reg);
    assign c_b_val = c_vb_reg ? c_rdb_reg : W'(c_zb_reg);
    assign b_val   = b_v_reg  ? b_rd_reg  : W'(b_z_reg);

    assign s_ready        = (state_reg == bmm_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = out_val_reg;
    assign m_is_length    = out_len_reg;
    assign m_overflow     = out_ovf_reg;
    assign m_last_result  = out_last_reg;

    bmm_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_waddr] <= c_wdata;
        end
        if (b_we) begin
            b_mem[idx_reg] <= b_wdata;
        end
        if (h_we) begin
            h_mem[cnt_reg[HW-1:0]] <= s_symbol;
        end
        c_rda_reg <= c_mem[c_ra];
        c_rdb_reg <= c_mem[c_rb];
        b_rd_reg  <= b_mem[b_raddr];
        h_rd_reg  <= h_mem[h_raddr];
        c_va_reg  <= c_vld_reg[c_ra];
        c_vb_reg  <= c_vld_reg[c_rb];
        b_v_reg   <= b_vld_reg[b_raddr];
        c_za_reg  <= (c_ra == '0);
        c_zb_reg  <= (c_rb == '0);
        b_z_reg   <= (b_raddr == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            c_vld_reg <= '0;
            b_vld_reg <= '0;
        end else begin
            if (c_we) begin
                c_vld_reg[c_waddr] <= 1'b1;
            end
            if (b_we) begin
                b_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= bmm_pkg::MOD_RESET;
        end else if (cfg_we) begin
            modulus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bmm_pkg::ST_IDLE;
            cnt_reg     <= '0;
            len_reg     <= '0;
            lui_reg     <= '1;
            ld_reg      <= W'(1);
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            lui_reg     <= lui_next;
            ld_reg      <= ld_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        eos_reg      <= eos_next;
        d_reg        <= d_next;
        idx_reg      <= idx_next;
        lenchg_reg   <= lenchg_next;
        f_reg        <= f_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        t0_reg       <= t0_next;
        t1_reg       <= t1_next;
        prod_reg     <= prod_next;
        cj_reg       <= cj_next;
        sub_reg      <= sub_next;
        k_reg        <= k_next;
        out_val_reg  <= out_val_next;
        out_len_reg  <= out_len_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        lui_next      = lui_reg;
        ld_next       = ld_reg;
        ovf_next      = ovf_reg;
        eos_next      = eos_reg;
        d_next        = d_reg;
        idx_next      = idx_reg;
        lenchg_next   = lenchg_reg;
        f_next        = f_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        prod_next     = prod_reg;
        cj_next       = cj_reg;
        sub_next      = sub_reg;
        k_next        = k_reg;
        out_val_next  = out_val_reg;
        out_len_next  = out_len_reg;
        out_ovf_next  = out_ovf_reg;
        out_last_next = out_last_reg;
        m_valid_next  = m_acc ? 1'b0 : m_valid_reg;

        c_ra     = idx_reg;
        c_rb     = j_full[IW-1:0];
        b_raddr  = idx_reg;
        h_raddr  = HW'(cnt_reg - idx_reg);
        c_we     = 1'b0;
        c_waddr  = j_full[IW-1:0];
        c_wdata  = red_rem;
        b_we     = 1'b0;
        b_wdata  = c_a_val;
        h_we     = 1'b0;
        clr      = 1'b0;

        div_start    = 1'b0;
        div_dividend = {{(DW-2*W){1'b0}}, prod_reg};
        div_divisor  = modulus_reg;
        nt_sum       = '0;

        case (state_reg)
            bmm_pkg::ST_IDLE: begin
                if (s_acc) begin
                    eos_next = s_end_of_sequence;
                    k_next   = '0;
                    if (cnt_reg < IW'(MAX_SEQ)) begin
                        h_we         = 1'b1;
                        div_start    = 1'b1;
                        div_dividend = DW'(s_symbol);
                        state_next   = bmm_pkg::ST_DINIT_W;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_end_of_sequence) begin
                            state_next = bmm_pkg::ST_ORD;
                        end
                    end
                end
            end
            bmm_pkg::ST_DINIT_W: begin
                if (div_done) begin
                    d_next     = red_rem;
                    idx_next   = IW'(1);
                    state_next = bmm_pkg::ST_DRD;
                end
            end
            bmm_pkg::ST_DRD: begin
                if ((idx_reg <= len_reg) && (idx_reg <= cnt_reg)) begin
                    state_next = bmm_pkg::ST_DMUL;
                end else if (d_reg == '0) begin
                    state_next = bmm_pkg::ST_FIN;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'(ld_reg);
                    state_next   = bmm_pkg::ST_INV_W;
                end
            end
            bmm_pkg::ST_DMUL: begin
                prod_next  = c_a_val * h_rd_reg;
                state_next = bmm_pkg::ST_DRED;
            end
            bmm_pkg::ST_DRED: begin
                div_start    = 1'b1;
                div_dividend = {1'b0, prod_reg} + DW'(d_reg);
                state_next   = bmm_pkg::ST_DRED_W;
            end
            bmm_pkg::ST_DRED_W: begin
                if (div_done) begin
                    d_next     = red_rem;
                    idx_next   = idx_reg + 1'b1;
                    state_next = bmm_pkg::ST_DRD;
                end
            end
            bmm_pkg::ST_INV_W: begin
                if (div_done) begin
                    r0_next    = modulus_reg;
                    r1_next    = div_rem;
                    t0_next    = '0;
                    t1_next    = W'(1);
                    state_next = bmm_pkg::ST_EUC;
                end
            end
            bmm_pkg::ST_EUC: begin
                if (r1_reg == '0) begin
                    state_next = bmm_pkg::ST_FMUL;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = DW'(r0_reg);
                    div_divisor  = r1_reg;
                    state_next   = bmm_pkg::ST_EDIV_W;
                end
            end
            bmm_pkg::ST_EDIV_W: begin
                div_divisor = r1_reg;
                if (div_done) begin
                    r0_next    = r1_reg;
                    r1_next    = div_rem;
                    state_next = bmm_pkg::ST_EMUL;
                end
            end
            bmm_pkg::ST_EMUL: begin
                prod_next  = div_quot * t1_reg;
                state_next = bmm_pkg::ST_ERED;
            end
            bmm_pkg::ST_ERED: begin
                div_start  = 1'b1;
                state_next = bmm_pkg::ST_ERED_W;
            end
            bmm_pkg::ST_ERED_W: begin
                if (div_done) begin
                    if (t0_reg >= div_rem) begin
                        nt_sum = {1'b0, t0_reg} - {1'b0, div_rem};
                    end else begin
                        nt_sum = {1'b0, t0_reg} + {1'b0, modulus_reg} - {1'b0, div_rem};
                    end
                    t0_next    = t1_reg;
                    t1_next    = nt_sum[W-1:0];
                    state_next = bmm_pkg::ST_EUC;
                end
            end
            bmm_pkg::ST_FMUL: begin
                prod_next  = d_reg * t0_reg;
                state_next = bmm_pkg::ST_FRED;
            end
            bmm_pkg::ST_FRED: begin
                div_start  = 1'b1;
                state_next = bmm_pkg::ST_FRED_W;
            end
            bmm_pkg::ST_FRED_W: begin
                if (div_done) begin
                    f_next      = red_rem;
                    idx_next    = IW'(MAX_SEQ);
                    lenchg_next = ({len_reg, 1'b0} <= ({1'b0, cnt_reg} + 1'b1));
                    state_next  = bmm_pkg::ST_URD;
                end
            end
            bmm_pkg::ST_URD: begin
                state_next = bmm_pkg::ST_UMUL;
            end
            bmm_pkg::ST_UMUL: begin
                prod_next = f_reg * b_val;
                cj_next   = c_b_val;
                b_we      = lenchg_reg;
                if (j_in) begin
                    state_next = bmm_pkg::ST_URED;
                end else begin
                    state_next = bmm_pkg::ST_UNXT;
                end
            end
            bmm_pkg::ST_URED: begin
                div_start  = 1'b1;
                state_next = bmm_pkg::ST_URED_W;
            end
            bmm_pkg::ST_URED_W: begin
                if (div_done) begin
                    sub_next   = {1'b0, cj_reg} + {1'b0, modulus_reg} - {1'b0, red_rem};
                    state_next = bmm_pkg::ST_USUB;
                end
            end
            bmm_pkg::ST_USUB: begin
                div_start    = 1'b1;
                div_dividend = DW'(sub_reg);
                state_next   = bmm_pkg::ST_USUB_W;
            end
            bmm_pkg::ST_USUB_W: begin
                if (div_done) begin
                    c_we       = 1'b1;
                    state_next = bmm_pkg::ST_UNXT;
                end
            end
            bmm_pkg::ST_UNXT: begin
                if (idx_reg == '0) begin
                    if (lenchg_reg) begin
                        len_next = cnt_reg + 1'b1 - len_reg;
                        lui_next = {1'b0, cnt_reg};
                        ld_next  = d_reg;
                    end
                    state_next = bmm_pkg::ST_FIN;
                end else begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = bmm_pkg::ST_URD;
                end
            end
            bmm_pkg::ST_FIN: begin
                cnt_next = cnt_reg + 1'b1;
                if (eos_reg) begin
                    state_next = bmm_pkg::ST_ORD;
                end else begin
                    state_next = bmm_pkg::ST_IDLE;
                end
            end
            bmm_pkg::ST_ORD: begin
                c_ra = IW'(({1'b0, len_reg} + 1'b1) - (IW+1)'(k_reg));
                if (slot_free) begin
                    state_next = bmm_pkg::ST_OLD;
                end
            end
            bmm_pkg::ST_OLD: begin
                out_len_next  = (k_reg == '0);
                out_val_next  = (k_reg == '0) ? W'(len_reg) : c_a_val;
                out_ovf_next  = ovf_reg;
                out_last_next = ((IW+1)'(k_reg) == ({1'b0, len_reg} + 1'b1));
                m_valid_next  = 1'b1;
                if ((IW+1)'(k_reg) == ({1'b0, len_reg} + 1'b1)) begin
                    clr        = 1'b1;
                    cnt_next   = '0;
                    len_next   = '0;
                    lui_next   = '1;
                    ld_next    = W'(1);
                    ovf_next   = 1'b0;
                    state_next = bmm_pkg::ST_IDLE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = bmm_pkg::ST_ORD;
                end
            end
            default: begin
                state_next = bmm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
